FILE: design/ipdd_pkg.sv
// ----------------------------------------------------------------------------
// ipdd_pkg: shared types and constants for the interrupt pending dispatcher
// Request and result payload structs, action codes, snapshot masks and
// interrupt number mapping constants.
// ----------------------------------------------------------------------------
package ipdd_pkg;

  // Action codes carried in a request
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_NEXT = 1'b1;

  // Field widths
  localparam int CORE_W   = 12;
  localparam int BASIC_W  = 21;
  localparam int WORD_W   = 32;
  localparam int IRQ_W    = 7;
  localparam int BIT_IDX_W = 5;
  // Wide enough for base + stride * 3 + 11 at the top of the base range
  localparam int CORE_NUM_W = 8;

  // Core source numbering
  localparam int CORE_BASE_NUMBER = 72;
  localparam int CORE_COUNT       = 4;
  localparam int CORE_STRIDE      = 12;

  // Basic word: keep bits 20..0, then drop the word 1 / word 2 summary bits
  localparam logic [BASIC_W-1:0] BASIC_KEEP = 21'h1FFCFF;
  localparam int BASIC_W1_BIT = 8;
  localparam int BASIC_W2_BIT = 9;
  // Word 1 without bits 7, 9, 10, 18, 19 (already seen in the basic word)
  localparam logic [WORD_W-1:0] WORD1_KEEP = 32'hFFF3_F97F;
  // Word 2 without bits 21..25 and 30 (already seen in the basic word)
  localparam logic [WORD_W-1:0] WORD2_KEEP = 32'hBC1F_FFFF;
  localparam logic [IRQ_W-1:0] WORD2_BASE  = 7'd32;

  typedef struct packed {
    logic              action;
    logic [1:0]        core_index;
    logic [CORE_W-1:0] core_source;
    logic [WORD_W-1:0] basic_pending;
    logic [WORD_W-1:0] pending_one;
    logic [WORD_W-1:0] pending_two;
  } ipdd_req_t;

  typedef struct packed {
    logic [IRQ_W-1:0] irq_number;
    logic             found;
    logic             last;
  } ipdd_rsp_t;

  // Index of the lowest set bit of a 32-bit word, 0 when empty
  function automatic logic [BIT_IDX_W-1:0] lowest_bit(input logic [WORD_W-1:0] w);
    logic [BIT_IDX_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        idx = BIT_IDX_W'(i);
      end
    end
    return idx;
  endfunction

  // Logical interrupt number for a basic pending bit
  function automatic logic [IRQ_W-1:0] basic_number(input logic [BIT_IDX_W-1:0] b);
    logic [IRQ_W-1:0] num;
    priority if (b < 5'd8) begin
      num = 7'd64 + IRQ_W'(b);
    end else if (b == 5'd10) begin
      num = 7'd7;
    end else if (b <= 5'd12) begin
      num = IRQ_W'(b) - 7'd2;
    end else if (b <= 5'd14) begin
      num = IRQ_W'(b) + 7'd5;
    end else if (b <= 5'd19) begin
      num = IRQ_W'(b) + 7'd38;
    end else begin
      num = 7'd62;
    end
    return num;
  endfunction

endpackage

FILE: design/interrupt_pending_dispatch_decoder_top.sv
// A next request's result is registered into out_data, or into the skid register while out_stall holds.
// Throughput: one request per cycle while in_stall is low; a load gives no result.
// A two-entry output stage (result register plus skid) holds one more result under stall.
// Reset (synchronous, rst_n low) clears the snapshot, the config register and all valids.
// ----------------------------------------------------------------------------
// interrupt_pending_dispatch_decoder_top: pending interrupt dispatcher
// Latches a snapshot of interrupt status on load and hands out one pending
// interrupt number per next request in fixed priority order.
// ----------------------------------------------------------------------------
module interrupt_pending_dispatch_decoder_top
  import ipdd_pkg::*;
#(
  parameter int CORE_BASE = CORE_BASE_NUMBER,
  parameter int NUM_CORES = CORE_COUNT
)
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  input  logic      in_valid,
  output logic      in_stall,
  input  ipdd_req_t in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output ipdd_rsp_t out_data
);

  logic                 core_present_r;
  logic [CORE_W-1:0]    core_left_r,   core_left_nxt;
  logic [1:0]           latched_core_r, latched_core_nxt;
  logic [BASIC_W-1:0]   basic_left_r,  basic_left_nxt;
  logic [WORD_W-1:0]    word1_left_r,  word1_left_nxt;
  logic [WORD_W-1:0]    word2_left_r,  word2_left_nxt;

  logic                 out_valid_r, skid_valid_r;
  ipdd_rsp_t            out_data_r, skid_data_r;

  logic                 in_acc, out_take, rsp_valid;
  ipdd_rsp_t            rsp;
  logic [BASIC_W-1:0]   basic_masked;
  logic [BIT_IDX_W-1:0] core_bit, basic_bit, word1_bit, word2_bit;
  logic [CORE_NUM_W-1:0] core_num;
  logic                 core_ok;

  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign rsp_valid = in_acc && (in_data.action == ACT_NEXT);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Lowest pending bit of each latched word
  assign core_bit  = lowest_bit(WORD_W'(core_left_r));
  assign basic_bit = lowest_bit(WORD_W'(basic_left_r));
  assign word1_bit = lowest_bit(word1_left_r);
  assign word2_bit = lowest_bit(word2_left_r);
  assign core_num  = CORE_NUM_W'(CORE_BASE)
                   + CORE_NUM_W'(latched_core_r) * CORE_NUM_W'(CORE_STRIDE)
                   + CORE_NUM_W'(core_bit);

  assign basic_masked = in_data.basic_pending[BASIC_W-1:0];
  assign core_ok      = core_present_r && ({1'b0, in_data.core_index} < 3'(NUM_CORES));

  // Load a snapshot or pick and clear the next pending interrupt
  always_comb begin
    core_left_nxt    = core_left_r;
    latched_core_nxt = latched_core_r;
    basic_left_nxt   = basic_left_r;
    word1_left_nxt   = word1_left_r;
    word2_left_nxt   = word2_left_r;
    rsp.irq_number   = '0;
    rsp.found        = 1'b0;
    if (in_acc && in_data.action == ACT_LOAD) begin
      latched_core_nxt = in_data.core_index;
      core_left_nxt    = core_ok ? in_data.core_source : '0;
      word1_left_nxt   = basic_masked[BASIC_W1_BIT] ? (in_data.pending_one & WORD1_KEEP) : '0;
      word2_left_nxt   = basic_masked[BASIC_W2_BIT] ? (in_data.pending_two & WORD2_KEEP) : '0;
      basic_left_nxt   = basic_masked & BASIC_KEEP;
    end else if (rsp_valid) begin
      priority if (|core_left_r) begin
        core_left_nxt  = core_left_r & (core_left_r - CORE_W'(1));
        rsp.irq_number = core_num[IRQ_W-1:0];
        rsp.found      = 1'b1;
      end else if (|basic_left_r) begin
        basic_left_nxt = basic_left_r & (basic_left_r - BASIC_W'(1));
        rsp.irq_number = basic_number(basic_bit);
        rsp.found      = 1'b1;
      end else if (|word1_left_r) begin
        word1_left_nxt = word1_left_r & (word1_left_r - WORD_W'(1));
        rsp.irq_number = IRQ_W'(word1_bit);
        rsp.found      = 1'b1;
      end else if (|word2_left_r) begin
        word2_left_nxt = word2_left_r & (word2_left_r - WORD_W'(1));
        rsp.irq_number = WORD2_BASE + IRQ_W'(word2_bit);
        rsp.found      = 1'b1;
      end else begin
        rsp.found      = 1'b0;
      end
    end
    rsp.last = !(|core_left_nxt || |basic_left_nxt || |word1_left_nxt || |word2_left_nxt);
  end

  // Hold config and snapshot state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      core_present_r <= 1'b0;
      core_left_r    <= '0;
      latched_core_r <= '0;
      basic_left_r   <= '0;
      word1_left_r   <= '0;
      word2_left_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        core_present_r <= cfg_wr_data;
      end
      core_left_r    <= core_left_nxt;
      latched_core_r <= latched_core_nxt;
      basic_left_r   <= basic_left_nxt;
      word1_left_r   <= word1_left_nxt;
      word2_left_r   <= word2_left_nxt;
    end
  end

  // Advance the result register and skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_take) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r  <= rsp_valid;
        end
      end else if (!out_valid_r) begin
        out_valid_r <= rsp_valid;
      end else if (rsp_valid) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  // Move result payloads
  always_ff @(posedge clk) begin
    if (out_take) begin
      out_data_r <= skid_valid_r ? skid_data_r : rsp;
    end else if (!out_valid_r) begin
      out_data_r <= rsp;
    end else if (rsp_valid) begin
      skid_data_r <= rsp;
    end
  end

endmodule
